/* design/pdf_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the pyramid down filter
// no dependencies; imported by every module of the block

package pdf_pkg;

   localparam int PIX_W     = 16;        // input sample
   localparam int LS_W      = 3 * PIX_W; // one column of the three stored rows
   localparam int ROW_W     = 16;        // row counter and height register
   localparam int WREG_W    = 11;        // width register
   localparam int XO_W      = 9;         // output column
   localparam int YO_W      = 15;        // output row
   localparam int HSUM_W    = 19;        // one weighted row of four taps
   localparam int VAL_W     = 22;        // full 4x4 weighted sum, 6 fraction bits
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   // register index, taken from paddr[2]
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // [row back][column back][bit]
   typedef logic [3:0][3:0][PIX_W-1:0] win_type;

   typedef struct packed {
      logic             restart;
      logic [ROW_W-1:0] height_last;
   } csr_ctl_type;

   // results owed for one accepted pixel
   typedef struct packed {
      logic [XO_W-1:0] x_first;
      logic            x_two;
      logic [1:0]      dx_first;   // column offset of the leftmost tap
      logic [YO_W-1:0] y_first;
      logic            y_two;
      logic [1:0]      dy_first;   // row offset of the topmost tap
      logic            image_end;
   } job_type;

endpackage

/* design/pdf_csr.sv */
`timescale 1ns / 1ps
// configuration registers: image width and height behind an apb-style port
// depends on pdf_pkg

module pdf_csr #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [pdf_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [pdf_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [pdf_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready,
   output logic [$clog2(MAX_WIDTH)-1:0]  width_last,
   output pdf_pkg::csr_ctl_type          ctl
);
   import pdf_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic [WREG_W-1:0] width_ff;
   logic [ROW_W-1:0]  height_ff;
   logic              wr;
   logic              idx;

   assign csr_pready = 1'b1;
   assign wr         = csr_psel & csr_penable & csr_pwrite;
   assign idx        = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WREG_W'(1024);
         height_ff <= ROW_W'(1);
      end else if (wr) begin
         case (idx)
            REG_WIDTH:  width_ff  <= csr_pwdata[WREG_W-1:0];
            REG_HEIGHT: height_ff <= csr_pwdata[ROW_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_WIDTH:  csr_prdata = CSR_DW'(width_ff);
         REG_HEIGHT: csr_prdata = CSR_DW'(height_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // zero counts as one, anything above the line store counts as its size
   always_comb begin
      if (width_ff == '0) begin
         width_last = '0;
      end else if (int'(width_ff) > MAX_WIDTH) begin
         width_last = COL_W'(MAX_WIDTH - 1);
      end else begin
         width_last = COL_W'(width_ff - WREG_W'(1));
      end
   end

   assign ctl.height_last = (height_ff == '0) ? '0 : height_ff - ROW_W'(1);
   assign ctl.restart     = wr;

endmodule

/* design/pdf_line_store.sv */
`timescale 1ns / 1ps
// line store: three previous rows packed per column, registered read
// depends on pdf_pkg

module pdf_line_store #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
   input  logic [pdf_pkg::LS_W-1:0]      wr_data,
   input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
   output logic [pdf_pkg::LS_W-1:0]      rd_data
);
   import pdf_pkg::*;

   logic [LS_W-1:0] mem [MAX_WIDTH];
   logic [LS_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // one-column images read the column being written
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/pdf_window.sv */
`timescale 1ns / 1ps
// input stage: raster position, 4x4 tap window and the results owed per pixel
// depends on pdf_pkg

module pdf_window #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [pdf_pkg::PIX_W-1:0] req_pixel_value,
   input  pdf_pkg::csr_ctl_type             ctl,
   input  logic [$clog2(MAX_WIDTH)-1:0]     width_last,
   input  logic [pdf_pkg::LS_W-1:0]         rd_data,
   output logic [$clog2(MAX_WIDTH)-1:0]     rd_addr,
   output logic                             wr_en,
   output logic [$clog2(MAX_WIDTH)-1:0]     wr_addr,
   output logic [pdf_pkg::LS_W-1:0]         wr_data,
   output pdf_pkg::win_type                 win,
   output pdf_pkg::job_type                 job,
   output logic                             job_valid,
   input  logic                             job_take
);
   import pdf_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   win_type          win_ff, win_in;
   job_type          job_ff, job_in;
   logic             job_valid_ff, job_valid_in;
   logic             accept;
   logic             col_end, row_end;
   logic             c_ge2, r_ge2;
   logic             x_emit, y_emit;
   logic [COL_W-2:0] c_half;
   logic [ROW_W-2:0] r_half;

   assign req_ready = !job_valid_ff || job_take;
   assign accept    = req_valid && req_ready;

   assign col_end = (col_ff == width_last);
   assign row_end = (row_ff == ctl.height_last);
   assign c_half  = col_ff[COL_W-1:1];
   assign r_half  = row_ff[ROW_W-1:1];
   assign c_ge2   = |c_half;
   assign r_ge2   = |r_half;
   assign x_emit  = col_end || (!col_ff[0] && c_ge2);
   assign y_emit  = row_end || (!row_ff[0] && r_ge2);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (ctl.restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // read ahead at the column of the next pixel
   assign rd_addr = col_in;
   assign wr_en   = accept;
   assign wr_addr = col_ff;
   assign wr_data = {rd_data[2*PIX_W-1:0], req_pixel_value};

   always_comb begin
      win_in = win_ff;
      if (accept) begin
         for (int k = 0; k < 4; k++) begin
            for (int m = 3; m > 0; m--) begin
               win_in[k][m] = (col_ff == '0) ? '0 : win_ff[k][m-1];
            end
         end
         win_in[0][0] = req_pixel_value;
         win_in[1][0] = (row_ff >= ROW_W'(1)) ? rd_data[PIX_W-1:0] : '0;
         win_in[2][0] = (row_ff >= ROW_W'(2)) ? rd_data[2*PIX_W-1:PIX_W] : '0;
         win_in[3][0] = (row_ff >= ROW_W'(3)) ? rd_data[3*PIX_W-1:2*PIX_W] : '0;
      end
   end

   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      if (accept) begin
         job_valid_in = x_emit && y_emit;
         // odd position is the last of an even size; even at the end adds one more
         if (col_ff[0]) begin
            job_in.x_first  = XO_W'(c_half);
            job_in.dx_first = 2'd2;
         end else if (c_ge2) begin
            job_in.x_first  = XO_W'(c_half) - XO_W'(1);
            job_in.dx_first = 2'd3;
         end else begin
            job_in.x_first  = '0;
            job_in.dx_first = 2'd1;
         end
         if (row_ff[0]) begin
            job_in.y_first  = YO_W'(r_half);
            job_in.dy_first = 2'd2;
         end else if (r_ge2) begin
            job_in.y_first  = YO_W'(r_half) - YO_W'(1);
            job_in.dy_first = 2'd3;
         end else begin
            job_in.y_first  = '0;
            job_in.dy_first = 2'd1;
         end
         job_in.x_two     = col_end && !col_ff[0] && c_ge2;
         job_in.y_two     = row_end && !row_ff[0] && r_ge2;
         job_in.image_end = col_end && row_end;
      end else if (job_take) begin
         job_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         job_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         job_valid_ff <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      job_ff <= job_in;
   end

   assign win       = win_ff;
   assign job       = job_ff;
   assign job_valid = job_valid_ff;

endmodule

/* design/pdf_reduce.sv */
`timescale 1ns / 1ps
// result side: steps through the owed outputs, row sums, column sum, output register
// depends on pdf_pkg

module pdf_reduce (
   input  logic                             clock,
   input  logic                             reset,
   input  pdf_pkg::win_type                 win,
   input  pdf_pkg::job_type                 job,
   input  logic                             job_valid,
   output logic                             job_take,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [pdf_pkg::VAL_W-1:0] rsp_out_value,
   output logic [pdf_pkg::XO_W-1:0]         rsp_out_column,
   output logic [pdf_pkg::YO_W-1:0]         rsp_out_row,
   output logic                             rsp_last_of_run,
   output logic                             rsp_image_done
);
   import pdf_pkg::*;

   // 1-3-3-1 over the taps at offsets d..0, nearest taps dropped past the edge
   function automatic logic signed [VAL_W-1:0] wsum4(
      input logic signed [VAL_W-1:0] s3,
      input logic signed [VAL_W-1:0] s2,
      input logic signed [VAL_W-1:0] s1,
      input logic signed [VAL_W-1:0] s0,
      input logic [1:0]              d
   );
      logic signed [VAL_W-1:0] t2, t1, t0;
      t2 = s2 + (s2 <<< 1);
      t1 = s1 + (s1 <<< 1);
      t0 = s0 + (s0 <<< 1);
      case (d)
         2'd3:    return s3 + t2 + t1 + s0;
         2'd2:    return s2 + t1 + t0;
         2'd1:    return s1 + t0;
         default: return '0;
      endcase
   endfunction

   logic                     seq_i_ff, seq_i_in;
   logic                     seq_j_ff, seq_j_in;
   logic                     step, cur_last, mid_ready, out_ready;
   logic [1:0]               dx, dy;
   logic signed [HSUM_W-1:0] hsum [4];

   logic                     mid_valid_ff, mid_valid_in;
   logic signed [HSUM_W-1:0] mid_hsum_ff [4];
   logic [1:0]               mid_dy_ff;
   logic [XO_W-1:0]          mid_ox_ff;
   logic [YO_W-1:0]          mid_oy_ff;
   logic                     mid_last_ff, mid_done_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0]  out_value_ff;
   logic [XO_W-1:0]          out_col_ff;
   logic [YO_W-1:0]          out_row_ff;
   logic                     out_last_ff, out_done_ff;

   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign mid_ready = !mid_valid_ff || out_ready;
   assign step      = job_valid && mid_ready;
   assign cur_last  = (seq_j_ff == job.x_two) && (seq_i_ff == job.y_two);
   assign job_take  = step && cur_last;

   // second column or row of a pair always starts one tap in
   assign dx = seq_j_ff ? 2'd1 : job.dx_first;
   assign dy = seq_i_ff ? 2'd1 : job.dy_first;

   always_comb begin
      seq_i_in = seq_i_ff;
      seq_j_in = seq_j_ff;
      if (step) begin
         if (cur_last) begin
            seq_i_in = 1'b0;
            seq_j_in = 1'b0;
         end else if (!seq_j_ff && job.x_two) begin
            seq_j_in = 1'b1;
         end else begin
            seq_j_in = 1'b0;
            seq_i_in = 1'b1;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         hsum[k] = HSUM_W'(wsum4(VAL_W'($signed(win[k][3])), VAL_W'($signed(win[k][2])),
                                 VAL_W'($signed(win[k][1])), VAL_W'($signed(win[k][0])), dx));
      end
   end

   assign mid_valid_in = mid_ready ? job_valid : mid_valid_ff;
   assign rsp_valid_in = out_ready ? mid_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_i_ff     <= 1'b0;
         seq_j_ff     <= 1'b0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_i_ff     <= seq_i_in;
         seq_j_ff     <= seq_j_in;
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         for (int k = 0; k < 4; k++) begin
            mid_hsum_ff[k] <= hsum[k];
         end
         mid_dy_ff   <= dy;
         mid_ox_ff   <= job.x_first + XO_W'(seq_j_ff);
         mid_oy_ff   <= job.y_first + YO_W'(seq_i_ff);
         mid_last_ff <= cur_last;
         mid_done_ff <= cur_last && job.image_end;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && mid_valid_ff) begin
         out_value_ff <= wsum4(VAL_W'(mid_hsum_ff[3]), VAL_W'(mid_hsum_ff[2]),
                               VAL_W'(mid_hsum_ff[1]), VAL_W'(mid_hsum_ff[0]), mid_dy_ff);
         out_col_ff   <= mid_ox_ff;
         out_row_ff   <= mid_oy_ff;
         out_last_ff  <= mid_last_ff;
         out_done_ff  <= mid_done_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_value   = out_value_ff;
   assign rsp_out_column  = out_col_ff;
   assign rsp_out_row     = out_row_ff;
   assign rsp_last_of_run = out_last_ff;
   assign rsp_image_done  = out_done_ff;

`ifndef SYNTHESIS
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_done_ff |-> out_last_ff)
      else $error("image end flagged on a word that does not close its pixel");

   a_second_col: assert property (@(posedge clock) disable iff (reset)
      seq_j_ff |-> job_valid && job.x_two)
      else $error("second output column stepped without a pending pair");

   a_second_row: assert property (@(posedge clock) disable iff (reset)
      seq_i_ff |-> job_valid && job.y_two)
      else $error("second output row stepped without a pending pair");

   a_take_rewinds: assert property (@(posedge clock) disable iff (reset)
      job_take |=> !seq_i_ff && !seq_j_ff)
      else $error("result sequencer not rewound after the last word of a pixel");
`endif

endmodule

/* design/pyramid_down_filter_top.sv */
`timescale 1ns / 1ps
// pyramid down filter, top level: halves one signed image channel with a 1-3-3-1 kernel
// depends on pdf_pkg, pdf_csr, pdf_line_store, pdf_window, pdf_reduce
//
// usage:
//   req_*   takes one 16-bit pixel word per accepted handshake, raster order.
//   rsp_*   gives output words: 22-bit sum with 6 fraction bits, output column
//           and row, last_of_run on the final word a pixel causes, image_done on
//           the final word of the image.
//   csr_*   width (byte 0) and height (byte 4); a write restarts the image.
//           write only while the block is idle.
// path: the pixel that completes the window is registered with its job, then its
//   row sums in the mid register, then the column sum in the output register.
// throughput: one pixel per cycle while each pixel causes at most one word and
//   rsp_ready holds; a row-end or image-end pixel that causes n words (up to 4)
//   holds the result sequencer for them, one word per cycle while rsp_ready holds.
// reset: position returns to the first pixel, width 1024, height 1. the line
//   store is not cleared; rows above the top edge are masked to zero.
// stall: words wait in the output register; one pending pixel and one word in
//   flight are held behind it before req_ready drops.

module pyramid_down_filter_top #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [pdf_pkg::PIX_W-1:0] req_pixel_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [pdf_pkg::VAL_W-1:0] rsp_out_value,
   output logic [pdf_pkg::XO_W-1:0]         rsp_out_column,
   output logic [pdf_pkg::YO_W-1:0]         rsp_out_row,
   output logic                             rsp_last_of_run,
   output logic                             rsp_image_done,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pdf_pkg::CSR_AW-1:0]       csr_paddr,
   input  logic [pdf_pkg::CSR_DW-1:0]       csr_pwdata,
   output logic [pdf_pkg::CSR_DW-1:0]       csr_prdata,
   output logic                             csr_pready
);
   import pdf_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   csr_ctl_type      ctl;
   logic [COL_W-1:0] width_last;
   logic [LS_W-1:0]  rd_data;
   logic [COL_W-1:0] rd_addr;
   logic             wr_en;
   logic [COL_W-1:0] wr_addr;
   logic [LS_W-1:0]  wr_data;
   win_type          win;
   job_type          job;
   logic             job_valid;
   logic             job_take;

   pdf_csr #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .width_last  (width_last),
      .ctl         (ctl)
   );

   pdf_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pdf_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_value (req_pixel_value),
      .ctl             (ctl),
      .width_last      (width_last),
      .rd_data         (rd_data),
      .rd_addr         (rd_addr),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .win             (win),
      .job             (job),
      .job_valid       (job_valid),
      .job_take        (job_take)
   );

   pdf_reduce u_reduce (
      .clock           (clock),
      .reset           (reset),
      .win             (win),
      .job             (job),
      .job_valid       (job_valid),
      .job_take        (job_take),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_value   (rsp_out_value),
      .rsp_out_column  (rsp_out_column),
      .rsp_out_row     (rsp_out_row),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_image_done  (rsp_image_done)
   );

endmodule
